/* design/hrhs_pkg.sv */
// shared types and constants for the http request head splitter
package hrhs_pkg;

    localparam int WIN_DEPTH  = 5;
    localparam int HEADER_CAP = 16;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_SP = 8'h20;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_URI       = 3'd1,
        EV_VERSION   = 3'd2,
        EV_HDR_NAME  = 3'd3,
        EV_HDR_VALUE = 3'd4,
        EV_HEAD_END  = 3'd5
    } field_event_t;

    // one byte of the delay window with its tags
    typedef struct packed {
        logic [7:0]   val;
        logic [15:0]  off;
        field_event_t ev;
        logic [3:0]   idx;
    } slot_t;

    // one result beat
    typedef struct packed {
        slot_t      slot;
        logic [4:0] total;
        logic       ovf;
        logic       last;
    } result_t;

endpackage

/* design/http_request_head_splitter_core.sv */
// http request head splitter: delay window, delimiter marking and output skid
//
// channel  direction  handshake          payload
// s_       in         s_valid/s_ready    s_data_byte, s_end_of_buffer
// m_       out        m_valid/m_ready    m_out_byte .. m_last_out
// cfg_     in         cfg_we             cfg_wdata (header_limit)
//
// one input beat per cycle when no flush runs and the skid is empty; a byte
// leaves when the window is full and another is accepted. an end_of_buffer beat
// flushes the window: 1 to 5 beats, s_ready low, one per cycle if skid is empty.
// a two-entry output stage (register plus skid) keeps s_ready off m_ready.
// reset is synchronous and clears the window fill, counters and valids.
module http_request_head_splitter_core #(
    parameter int HEADER_SLOTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_buffer,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic [15:0] m_byte_offset,
    output logic [2:0]  m_field_event,
    output logic [3:0]  m_header_index,
    output logic [4:0]  m_header_total,
    output logic        m_header_overflow,
    output logic        m_last_out
);

    localparam int LIMIT_CAP_INT = (HEADER_SLOTS < hrhs_pkg::HEADER_CAP) ?
                                   HEADER_SLOTS : hrhs_pkg::HEADER_CAP;
    localparam logic [4:0] LIMIT_CAP = 5'(LIMIT_CAP_INT);
    localparam logic [2:0] FULL_FILL = 3'(hrhs_pkg::WIN_DEPTH - 1);

    logic [4:0]  header_limit_reg;

    hrhs_pkg::slot_t window_reg  [hrhs_pkg::WIN_DEPTH];
    hrhs_pkg::slot_t window_next [hrhs_pkg::WIN_DEPTH];
    hrhs_pkg::slot_t win_in      [hrhs_pkg::WIN_DEPTH];
    hrhs_pkg::slot_t ex_win      [hrhs_pkg::WIN_DEPTH];
    hrhs_pkg::slot_t new_slot;

    logic [2:0]  fill_reg;
    logic [15:0] position_reg;
    logic [1:0]  line_spaces_reg,  line_spaces_next;
    logic [4:0]  line_number_reg,  line_number_next;
    logic        uri_seen_reg,     uri_seen_next;
    logic        version_seen_reg, version_seen_next;
    logic        value_seen_reg,   value_seen_next;
    logic [4:0]  names_counted_reg, names_counted_next;
    logic        head_done_reg,    head_done_next;
    logic        overflow_reg,     overflow_next;
    logic [2:0]  drain_left_reg;

    hrhs_pkg::result_t out_reg, skid_reg, push_data;
    logic        m_valid_reg;
    logic        skid_valid_reg;

    logic        s_accept;
    logic        step_emit;
    logic        drain_push;
    logic        push;
    logic        draining;
    logic        is_end, is_crlf, kept;
    logic [4:0]  line;
    logic [4:0]  limit;

    assign draining   = (drain_left_reg != 3'd0);
    assign s_ready    = !draining && !skid_valid_reg;
    assign s_accept   = s_valid && s_ready;
    assign step_emit  = s_accept && !s_end_of_buffer && (fill_reg == FULL_FILL);
    assign drain_push = draining && !skid_valid_reg;
    assign push       = step_emit || drain_push;

    assign limit = (header_limit_reg < LIMIT_CAP) ? header_limit_reg : LIMIT_CAP;

    always_comb begin
        new_slot.val = s_data_byte;
        new_slot.off = position_reg;
        new_slot.ev  = hrhs_pkg::EV_NONE;
        new_slot.idx = 4'd0;
        for (int k = 0; k < hrhs_pkg::WIN_DEPTH - 1; k++) begin
            win_in[k] = window_reg[k];
        end
        win_in[hrhs_pkg::WIN_DEPTH - 1] = new_slot;
    end

    // judge the byte in slot 1 against its neighbors
    always_comb begin
        ex_win             = win_in;
        line_spaces_next   = line_spaces_reg;
        line_number_next   = line_number_reg;
        uri_seen_next      = uri_seen_reg;
        version_seen_next  = version_seen_reg;
        value_seen_next    = value_seen_reg;
        names_counted_next = names_counted_reg;
        head_done_next     = head_done_reg;
        overflow_next      = overflow_reg;
        is_end  = 1'b0;
        is_crlf = 1'b0;
        line    = line_number_reg - 5'd1;
        kept    = 1'b0;
        if (!head_done_reg) begin
            if (win_in[1].val == hrhs_pkg::CHAR_SP) begin
                if (line_spaces_reg != 2'd3) begin
                    line_spaces_next = line_spaces_reg + 2'd1;
                end
            end else if (win_in[1].val == hrhs_pkg::CHAR_CR &&
                         win_in[2].val == hrhs_pkg::CHAR_LF &&
                         win_in[3].val == hrhs_pkg::CHAR_CR &&
                         win_in[4].val == hrhs_pkg::CHAR_LF) begin
                is_end = 1'b1;
            end else if (win_in[1].val == hrhs_pkg::CHAR_CR &&
                         win_in[2].val == hrhs_pkg::CHAR_LF) begin
                is_crlf = 1'b1;
                if (line_number_reg != 5'd31) begin
                    line_number_next = line_number_reg + 5'd1;
                end
                line_spaces_next = 2'd0;
                value_seen_next  = 1'b0;
            end

            line = line_number_next - 5'd1;
            kept = (line < limit);

            if (is_end) begin
                for (int k = 1; k < hrhs_pkg::WIN_DEPTH; k++) begin
                    ex_win[k].val = 8'd0;
                end
                ex_win[1].ev   = hrhs_pkg::EV_HEAD_END;
                ex_win[1].idx  = 4'd0;
                head_done_next = 1'b1;
            end else if (line_number_next == 5'd0) begin
                // request line: method, uri, version
                if (line_spaces_next == 2'd1 && !uri_seen_reg) begin
                    uri_seen_next = 1'b1;
                    ex_win[1].val = 8'd0;
                    ex_win[2].ev  = hrhs_pkg::EV_URI;
                    ex_win[2].idx = 4'd0;
                end else if (line_spaces_next == 2'd2 && !version_seen_reg) begin
                    version_seen_next = 1'b1;
                    ex_win[1].val = 8'd0;
                    ex_win[2].ev  = hrhs_pkg::EV_VERSION;
                    ex_win[2].idx = 4'd0;
                end
            end else if (is_crlf) begin
                if (kept) begin
                    names_counted_next = names_counted_reg + 5'd1;
                    ex_win[1].val = 8'd0;
                    ex_win[2].val = 8'd0;
                    ex_win[3].ev  = hrhs_pkg::EV_HDR_NAME;
                    ex_win[3].idx = line[3:0];
                end else begin
                    overflow_next = 1'b1;
                end
            end else if (line_spaces_next == 2'd1 && !value_seen_reg) begin
                value_seen_next = 1'b1;
                if (kept) begin
                    // zero the colon and the space
                    ex_win[1].val = 8'd0;
                    ex_win[0].val = 8'd0;
                    ex_win[2].ev  = hrhs_pkg::EV_HDR_VALUE;
                    ex_win[2].idx = line[3:0];
                end else begin
                    overflow_next = 1'b1;
                end
            end
        end
    end

    always_comb begin
        window_next = window_reg;
        if (s_accept) begin
            if (s_end_of_buffer || fill_reg != FULL_FILL) begin
                window_next[fill_reg] = new_slot;
            end else begin
                for (int k = 0; k < hrhs_pkg::WIN_DEPTH - 1; k++) begin
                    window_next[k] = ex_win[k + 1];
                end
            end
        end else if (drain_push) begin
            for (int k = 0; k < hrhs_pkg::WIN_DEPTH - 1; k++) begin
                window_next[k] = window_reg[k + 1];
            end
        end
    end

    always_comb begin
        if (step_emit) begin
            push_data.slot  = ex_win[0];
            push_data.total = names_counted_next;
            push_data.ovf   = overflow_next;
            push_data.last  = 1'b0;
        end else begin
            push_data.slot  = window_reg[0];
            push_data.total = names_counted_reg;
            push_data.ovf   = overflow_reg;
            push_data.last  = (drain_left_reg == 3'd1);
        end
    end

    always_ff @(posedge aclk) begin
        window_reg <= window_next;

        if (!aresetn) begin
            header_limit_reg <= 5'd16;
        end else if (cfg_we) begin
            header_limit_reg <= cfg_wdata;
        end

        if (!aresetn) begin
            fill_reg         <= 3'd0;
            position_reg     <= 16'd0;
            line_spaces_reg  <= 2'd0;
            line_number_reg  <= 5'd0;
            uri_seen_reg     <= 1'b0;
            version_seen_reg <= 1'b0;
            value_seen_reg   <= 1'b0;
            names_counted_reg <= 5'd0;
            head_done_reg    <= 1'b0;
            overflow_reg     <= 1'b0;
            drain_left_reg   <= 3'd0;
        end else if (s_accept) begin
            if (position_reg != 16'hFFFF) begin
                position_reg <= position_reg + 16'd1;
            end
            if (s_end_of_buffer) begin
                drain_left_reg <= fill_reg + 3'd1;
            end else if (fill_reg != FULL_FILL) begin
                fill_reg <= fill_reg + 3'd1;
            end else begin
                line_spaces_reg   <= line_spaces_next;
                line_number_reg   <= line_number_next;
                uri_seen_reg      <= uri_seen_next;
                version_seen_reg  <= version_seen_next;
                value_seen_reg    <= value_seen_next;
                names_counted_reg <= names_counted_next;
                head_done_reg     <= head_done_next;
                overflow_reg      <= overflow_next;
            end
        end else if (drain_push) begin
            drain_left_reg <= drain_left_reg - 3'd1;
            if (drain_left_reg == 3'd1) begin
                // last flush beat: back to the start of a buffer
                fill_reg          <= 3'd0;
                position_reg      <= 16'd0;
                line_spaces_reg   <= 2'd0;
                line_number_reg   <= 5'd0;
                uri_seen_reg      <= 1'b0;
                version_seen_reg  <= 1'b0;
                value_seen_reg    <= 1'b0;
                names_counted_reg <= 5'd0;
                head_done_reg     <= 1'b0;
                overflow_reg      <= 1'b0;
            end
        end

        // output register with skid entry
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (push) begin
            if (!m_valid_reg || m_ready) begin
                out_reg     <= push_data;
                m_valid_reg <= 1'b1;
            end else begin
                skid_reg       <= push_data;
                skid_valid_reg <= 1'b1;
            end
        end else if (m_valid_reg && m_ready) begin
            if (skid_valid_reg) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_out_byte        = out_reg.slot.val;
    assign m_byte_offset     = out_reg.slot.off;
    assign m_field_event     = out_reg.slot.ev;
    assign m_header_index    = out_reg.slot.idx;
    assign m_header_total    = out_reg.total;
    assign m_header_overflow = out_reg.ovf;
    assign m_last_out        = out_reg.last;

    // an end-of-buffer beat always starts a flush
    a_eob_starts_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_end_of_buffer |=> drain_left_reg != 3'd0)
        else $error("end-of-buffer beat did not start a flush");

    // the skid entry only fills behind a waiting output beat
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid entry held without an output beat");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FULL_FILL)
        else $error("window fill out of range");

    // header counts stay frozen while a flush is in progress
    a_flush_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        drain_left_reg > 3'd1 |=> $stable(names_counted_reg) && $stable(overflow_reg))
        else $error("header counters changed during flush");

endmodule

/* test/hrhs_result_monitor.sv */
// result monitor: predicts the split byte stream and compares every output beat
module hrhs_result_monitor #(
    parameter int HEADER_SLOTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_buffer,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_out_byte,
    input  logic [15:0] m_byte_offset,
    input  logic [2:0]  m_field_event,
    input  logic [3:0]  m_header_index,
    input  logic [4:0]  m_header_total,
    input  logic        m_header_overflow,
    input  logic        m_last_out,
    output int          fail_count,
    output int          pending
);

    hrhs_pkg::slot_t   win [hrhs_pkg::WIN_DEPTH];
    int unsigned       fill;
    int unsigned       pos;
    int unsigned       spaces;
    int unsigned       line_no;
    int unsigned       names;
    int unsigned       limit_reg;
    bit                uri_done;
    bit                ver_done;
    bit                val_done;
    bit                head_fin;
    bit                ovf;
    hrhs_pkg::result_t expected_beats [$];
    int unsigned       err_total = 0;

    function automatic void clear_split_state();
        for (int k = 0; k < hrhs_pkg::WIN_DEPTH; k++) begin
            win[k] = '0;
        end
        fill = 0;
        pos = 0;
        spaces = 0;
        line_no = 0;
        names = 0;
        uri_done = 1'b0;
        ver_done = 1'b0;
        val_done = 1'b0;
        head_fin = 1'b0;
        ovf = 1'b0;
    endfunction

    // judge the byte in slot 1 against the one before and the three after
    function automatic void judge_window();
        bit          crlf;
        bit          fin;
        bit          kept;
        int unsigned ln;
        int unsigned lim;
        crlf = 1'b0;
        fin = 1'b0;
        if (win[1].val == hrhs_pkg::CHAR_SP) begin
            if (spaces < 3) spaces++;
        end else if (win[1].val == hrhs_pkg::CHAR_CR && win[2].val == hrhs_pkg::CHAR_LF &&
                     win[3].val == hrhs_pkg::CHAR_CR && win[4].val == hrhs_pkg::CHAR_LF) begin
            fin = 1'b1;
        end else if (win[1].val == hrhs_pkg::CHAR_CR && win[2].val == hrhs_pkg::CHAR_LF) begin
            crlf = 1'b1;
            if (line_no < 31) line_no++;
            spaces = 0;
            val_done = 1'b0;
        end

        if (fin) begin
            win[1].val = '0;
            win[2].val = '0;
            win[3].val = '0;
            win[4].val = '0;
            win[1].ev = hrhs_pkg::EV_HEAD_END;
            win[1].idx = '0;
            head_fin = 1'b1;
        end else if (line_no == 0) begin
            if (spaces == 1 && !uri_done) begin
                uri_done = 1'b1;
                win[1].val = '0;
                win[2].ev = hrhs_pkg::EV_URI;
                win[2].idx = '0;
            end else if (spaces == 2 && !ver_done) begin
                ver_done = 1'b1;
                win[1].val = '0;
                win[2].ev = hrhs_pkg::EV_VERSION;
                win[2].idx = '0;
            end
        end else begin
            ln = line_no - 1;
            lim = limit_reg;
            if (lim > HEADER_SLOTS) lim = HEADER_SLOTS;
            if (lim > hrhs_pkg::HEADER_CAP) lim = hrhs_pkg::HEADER_CAP;
            kept = (ln < lim);
            if (crlf) begin
                if (kept) begin
                    names++;
                    win[1].val = '0;
                    win[2].val = '0;
                    win[3].ev = hrhs_pkg::EV_HDR_NAME;
                    win[3].idx = ln[3:0];
                end else begin
                    ovf = 1'b1;
                end
            end else if (spaces == 1 && !val_done) begin
                val_done = 1'b1;
                if (kept) begin
                    // the space and the colon before it
                    win[1].val = '0;
                    win[0].val = '0;
                    win[2].ev = hrhs_pkg::EV_HDR_VALUE;
                    win[2].idx = ln[3:0];
                end else begin
                    ovf = 1'b1;
                end
            end
        end
    endfunction

    function automatic void queue_result(input hrhs_pkg::slot_t s, input bit last);
        hrhs_pkg::result_t r;
        r.slot = s;
        r.total = names[4:0];
        r.ovf = ovf;
        r.last = last;
        expected_beats.push_back(r);
    endfunction

    function automatic void predict_byte(input logic [7:0] b, input logic eob);
        if (fill >= hrhs_pkg::WIN_DEPTH) fill = hrhs_pkg::WIN_DEPTH - 1;
        win[fill].val = b;
        win[fill].off = pos[15:0];
        win[fill].ev = hrhs_pkg::EV_NONE;
        win[fill].idx = '0;
        fill++;
        if (pos < 65535) pos++;

        if (eob) begin
            // flush everything held, then back to the reset state
            for (int k = 0; k < fill; k++) begin
                queue_result(win[k], k + 1 == fill);
            end
            clear_split_state();
        end else if (fill == hrhs_pkg::WIN_DEPTH) begin
            if (!head_fin) judge_window();
            queue_result(win[0], 1'b0);
            for (int k = 0; k < hrhs_pkg::WIN_DEPTH - 1; k++) begin
                win[k] = win[k + 1];
            end
            win[hrhs_pkg::WIN_DEPTH - 1] = '0;
            fill = hrhs_pkg::WIN_DEPTH - 1;
        end
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            err_total++;
            if (err_total <= 40) begin
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            end
        end
    endfunction

    function automatic void compare_beat();
        hrhs_pkg::result_t e;
        if (expected_beats.size() == 0) begin
            err_total++;
            if (err_total <= 40) begin
                $display("%0t: output beat with nothing expected, expected none actual %0d",
                         $time, m_out_byte);
            end
            return;
        end
        e = expected_beats.pop_front();
        check_field("out_byte", e.slot.val, m_out_byte);
        check_field("byte_offset", e.slot.off, m_byte_offset);
        check_field("field_event", e.slot.ev, m_field_event);
        check_field("header_index", e.slot.idx, m_header_index);
        check_field("header_total", e.total, m_header_total);
        check_field("header_overflow", e.ovf, m_header_overflow);
        check_field("last_out", e.last, m_last_out);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_split_state();
            limit_reg = hrhs_pkg::HEADER_CAP;
            expected_beats.delete();
        end else begin
            // an output beat is always older than an input beat of the same edge
            if (m_valid && m_ready) compare_beat();
            if (cfg_we) limit_reg = cfg_wdata;
            if (s_valid && s_ready) predict_byte(s_data_byte, s_end_of_buffer);
        end
        fail_count <= err_total;
        pending <= expected_beats.size();
    end

endmodule

/* test/tb_http_request_head_splitter_core.sv */
// testbench top: request stimulus, output back-pressure and the final verdict
module tb_http_request_head_splitter_core;

    localparam int          CYCLE_LIMIT = 200_000;
    localparam logic [7:0]  CHAR_COLON  = 8'h3A;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [4:0]  cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = '0;
    logic        s_end_of_buffer = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_byte;
    logic [15:0] m_byte_offset;
    logic [2:0]  m_field_event;
    logic [3:0]  m_header_index;
    logic [4:0]  m_header_total;
    logic        m_header_overflow;
    logic        m_last_out;

    int          fail_count;
    int          pending;
    int unsigned cycle_count = 0;
    bit          tx_idle = 1'b1;
    bit          rx_idle = 1'b1;
    int unsigned rx_long = 0;
    logic [7:0]  req_bytes [$];

    http_request_head_splitter_core u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_data_byte       (s_data_byte),
        .s_end_of_buffer   (s_end_of_buffer),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_out_byte        (m_out_byte),
        .m_byte_offset     (m_byte_offset),
        .m_field_event     (m_field_event),
        .m_header_index    (m_header_index),
        .m_header_total    (m_header_total),
        .m_header_overflow (m_header_overflow),
        .m_last_out        (m_last_out)
    );

    hrhs_result_monitor u_monitor (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_data_byte       (s_data_byte),
        .s_end_of_buffer   (s_end_of_buffer),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_out_byte        (m_out_byte),
        .m_byte_offset     (m_byte_offset),
        .m_field_event     (m_field_event),
        .m_header_index    (m_header_index),
        .m_header_total    (m_header_total),
        .m_header_overflow (m_header_overflow),
        .m_last_out        (m_last_out),
        .fail_count        (fail_count),
        .pending           (pending)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_http_request_head_splitter_core: done, errors");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 7) return $urandom_range(1, 2);
        if (r < 9) return $urandom_range(3, 6);
        return $urandom_range(10, 30);
    endfunction

    function automatic logic [7:0] pick_letter();
        return 8'h61 + 8'($urandom_range(0, 25));
    endfunction

    function automatic void push_text(input string txt);
        for (int i = 0; i < txt.len(); i++) begin
            req_bytes.push_back(txt[i]);
        end
    endfunction

    function automatic void push_crlf();
        req_bytes.push_back(hrhs_pkg::CHAR_CR);
        req_bytes.push_back(hrhs_pkg::CHAR_LF);
    endfunction

    function automatic void push_letters(input int unsigned n);
        repeat (n) req_bytes.push_back(pick_letter());
    endfunction

    // request line, n_hdr header lines, blank line and a short tail
    function automatic void build_request(input int unsigned n_hdr, input bit terse);
        int unsigned r;
        req_bytes.delete();
        push_letters($urandom_range(1, 3));
        req_bytes.push_back(hrhs_pkg::CHAR_SP);
        push_letters($urandom_range(1, 3));
        if ($urandom_range(0, 5) == 0) req_bytes.push_back(hrhs_pkg::CHAR_SP);
        req_bytes.push_back(hrhs_pkg::CHAR_SP);
        push_letters($urandom_range(1, 3));
        if ($urandom_range(0, 5) == 0) begin
            req_bytes.push_back(hrhs_pkg::CHAR_SP);
            push_letters(1);
        end
        push_crlf();
        repeat (n_hdr) begin
            push_letters(terse ? 1 : $urandom_range(1, 3));
            if (!terse) begin
                req_bytes.push_back(CHAR_COLON);
                r = $urandom_range(0, 7);
                if (r != 0) req_bytes.push_back(hrhs_pkg::CHAR_SP);
                if (r == 1) req_bytes.push_back(hrhs_pkg::CHAR_SP);
                push_letters($urandom_range(0, 3));
            end
            push_crlf();
        end
        push_crlf();
        repeat ($urandom_range(0, 3)) req_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    task automatic send_beat(input logic [7:0] b, input logic eob);
        int unsigned gap;
        s_valid <= 1'b1;
        s_data_byte <= b;
        s_end_of_buffer <= eob;
        do @(posedge aclk); while (!s_ready);
        gap = (tx_idle && $urandom_range(0, 3) == 0) ? idle_len() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_buffer();
        for (int i = 0; i < req_bytes.size(); i++) begin
            send_beat(req_bytes[i], i == req_bytes.size() - 1);
        end
    endtask

    // sender parks until every expected beat is out and the block has settled
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (8) @(posedge aclk);
    endtask

    // receiver side, own process
    initial begin
        int unsigned hold;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else if (rx_long > 0) begin
                hold = rx_long - 1;
                rx_long = 0;
                m_ready <= 1'b0;
            end else if (rx_idle && $urandom_range(0, 3) == 0) begin
                hold = idle_len() - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        int unsigned plan [6];
        int unsigned sent;
        int unsigned nh;
        int unsigned kind;
        int unsigned keep;

        plan = '{0, 1, 31, 3, 16, 0};
        plan[5] = $urandom_range(0, 31);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: lone 0xff, a minimal request with every field, a short zero buffer
        req_bytes.delete();
        req_bytes.push_back(8'hFF);
        send_buffer();
        req_bytes.delete();
        push_text("G / V");
        push_crlf();
        push_text("A: b");
        push_crlf();
        push_crlf();
        push_text("Z");
        send_buffer();
        req_bytes.delete();
        repeat (4) req_bytes.push_back(8'h00);
        send_buffer();

        for (int ph = 0; ph < 6; ph++) begin
            wait_drained();
            cfg_we <= 1'b1;
            cfg_wdata <= plan[ph][4:0];
            @(posedge aclk);
            cfg_we <= 1'b0;
            tx_idle = (ph != 2 && ph != 3);
            rx_idle = (ph != 2);
            // long receiver stall while the sender keeps pushing
            if (ph == 3) rx_long = 80;
            if (ph == 4) begin
                // one header line more than the limit holds
                build_request(17, 1'b1);
                send_buffer();
            end else begin
                sent = 0;
                while (sent < 6) begin
                    kind = $urandom_range(0, 9);
                    nh = ($urandom_range(0, 5) == 0) ? $urandom_range(3, 4) :
                                                       $urandom_range(0, 2);
                    if (sent == 0 && ph == 3) begin
                        kind = 9;
                        nh = 3;
                    end
                    if (kind == 0) begin
                        // noise rich in delimiters
                        req_bytes.delete();
                        repeat ($urandom_range(1, 10)) begin
                            case ($urandom_range(0, 5))
                                0: req_bytes.push_back(hrhs_pkg::CHAR_CR);
                                1: req_bytes.push_back(hrhs_pkg::CHAR_LF);
                                2: req_bytes.push_back(hrhs_pkg::CHAR_SP);
                                default: req_bytes.push_back(8'($urandom_range(0, 255)));
                            endcase
                        end
                    end else begin
                        build_request(nh, 1'b0);
                        if (kind == 1) begin
                            keep = $urandom_range(1, req_bytes.size());
                            while (req_bytes.size() > keep) void'(req_bytes.pop_back());
                        end
                    end
                    send_buffer();
                    sent += req_bytes.size();
                end
            end
        end

        wait_drained();
        repeat (12) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_http_request_head_splitter_core: done, clean");
        end else begin
            $display("tb_http_request_head_splitter_core: done, errors");
        end
        $finish;
    end

endmodule

/* files.f */
design/hrhs_pkg.sv
design/http_request_head_splitter_core.sv
test/hrhs_result_monitor.sv
test/tb_http_request_head_splitter_core.sv
